// ===== rtl/core/heat_diffusion_stencil_unit_defines.svh =====
// assertion macros for the heat diffusion stencil unit
// no dependencies; included by the files that carry assertions
`ifndef HEAT_DIFFUSION_STENCIL_UNIT_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define HDS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hds assertion failed");

// next-cycle implication
`define HDS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hds assertion failed");

`else

`define HDS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define HDS_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/hds_pkg.sv =====
// shared types and constants for the heat diffusion stencil unit
// no dependencies; used by the interfaces, the line buffer and the top level
package hds_pkg;

    localparam int TEMP_BITS     = 16;
    localparam int ROW_BITS      = 12;
    localparam int OUT_COL_BITS  = 10;
    localparam int GW_BITS       = 11;
    localparam int GH_BITS       = 12;
    localparam int COEFF_BITS    = 15;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // coefficient is Q0.16
    localparam int FRAC_BITS = 16;
    // four neighbors summed minus four times center, signed
    localparam int SUM_BITS  = TEMP_BITS + 2;
    localparam int LAP_BITS  = TEMP_BITS + 3;
    localparam int PROD_BITS = COEFF_BITS + 1 + LAP_BITS;
    localparam int ACC_BITS  = TEMP_BITS + FRAC_BITS + 4;

    localparam int MIN_DIM = 3;

    localparam logic [GW_BITS-1:0]    GRID_WIDTH_RST  = GW_BITS'(200);
    localparam logic [GH_BITS-1:0]    GRID_HEIGHT_RST = GH_BITS'(200);
    localparam logic [COEFF_BITS-1:0] COEFF_RST       = COEFF_BITS'(16384);

    typedef logic [TEMP_BITS-1:0] temp_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_DIFF_COEFF  = 2'd2
    } cfg_reg_t;

    // line store read taps for one column
    typedef struct packed {
        temp_t up;
        temp_t center;
        temp_t right;
    } lb_taps_t;

endpackage

// ===== rtl/core/hds_if.sv =====
// channel interfaces for the heat diffusion stencil unit: input, result, config
// depends on hds_pkg
interface hds_in_if import hds_pkg::*; ();
    logic  valid;
    logic  ready;
    temp_t temperature_in;

    modport source (output valid, output temperature_in, input ready);
    modport sink (input valid, input temperature_in, output ready);
endinterface

interface hds_out_if import hds_pkg::*; ();
    logic                    valid;
    logic                    ready;
    temp_t                   temperature_out;
    logic [ROW_BITS-1:0]     out_row;
    logic [OUT_COL_BITS-1:0] out_col;
    logic                    last_of_run;

    modport source (output valid, output temperature_out, output out_row, output out_col,
                    output last_of_run, input ready);
    modport sink (input valid, input temperature_out, input out_row, input out_col,
                  input last_of_run, output ready);
endinterface

interface hds_cfg_if import hds_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/hds_line_buffer.sv =====
// two line stores (row above and row two above) with registered read taps
// depends on hds_pkg
module hds_line_buffer import hds_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_col,
    input  logic [AW-1:0] rd_col_right,
    output lb_taps_t      taps,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_col,
    input  temp_t         wr_temp
);

    temp_t    prev_mem [MAX_WIDTH];
    temp_t    older_mem [MAX_WIDTH];
    lb_taps_t taps_reg;

    // the column leaving the read stage shifts its center down into the older row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prev_mem[wr_col]  <= wr_temp;
            older_mem[wr_col] <= taps_reg.center;
        end
        if (rd_en)
        begin
            taps_reg.up     <= older_mem[rd_col];
            taps_reg.center <= prev_mem[rd_col];
            taps_reg.right  <= prev_mem[rd_col_right];
        end
    end

    assign taps = taps_reg;

endmodule

// ===== rtl/core/heat_diffusion_stencil_unit.sv =====
// heat diffusion stencil unit: one explicit five-point time step over a raster stream
// depends on hds_pkg, hds_if and hds_line_buffer
//
// usage
//   din carries one cell temperature (unsigned Q7.9) per item in raster order.
//   dout carries updated cells with their row and column; a cell comes out when
//   the cell below it arrives, so results trail the input by one row. cells of
//   the last row also emit themselves right after the cell above them.
//   cfg writes grid_width (0), grid_height (1) and diffusion_coeff (2, Q0.16);
//   any write to these restarts the grid at row 0, column 0. write only while idle.
// timing
//   four register stages: line store read, laplacian sum, multiply, round and
//   saturate into the output register. one item per cycle while dout is ready;
//   a last-row item gives two results, and the output register takes no new
//   item until both have been taken, which slows the last row.
// reset and stalls
//   reset loads the default registers and position 0,0; the line stores are not
//   cleared; row above fills in the first row, older row in the second. a stalled
//   receiver fills bubbles first; din.ready drops only once the read stage is held.
`include "heat_diffusion_stencil_unit_defines.svh"

module heat_diffusion_stencil_unit import hds_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input logic        clk,
    input logic        rst_n,
    hds_cfg_if.sink    cfg,
    hds_in_if.sink     din,
    hds_out_if.source  dout
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WCMP = (AW + 1 > GW_BITS) ? AW + 1 : GW_BITS;

    // configuration
    logic [GW_BITS-1:0]    grid_width_reg;
    logic [GH_BITS-1:0]    grid_height_reg;
    logic [COEFF_BITS-1:0] coeff_reg;
    logic                  cfg_wr;
    logic                  cfg_hit;

    logic [WCMP-1:0]     gw_ext;
    logic [WCMP-1:0]     eff_width;
    logic [AW-1:0]       col_last;
    logic [ROW_BITS-1:0] row_last;

    // position
    logic [AW-1:0]       col_count_reg;
    logic [ROW_BITS-1:0] row_count_reg;
    logic                col_at_last;
    logic                row_at_last;
    logic                in_fire;

    // read stage
    logic                s1_valid_reg;
    temp_t               s1_temp_reg;
    logic [ROW_BITS-1:0] s1_row_reg;
    logic [AW-1:0]       s1_col_reg;
    logic                s1_last_row_reg;
    logic                s1_col_last_reg;
    logic                s1_emit_reg;
    lb_taps_t            taps;
    temp_t               left_reg;
    logic [SUM_BITS-1:0] nbr_sum;
    logic signed [LAP_BITS-1:0] lap;

    // laplacian stage
    logic                       s2_valid_reg;
    logic signed [LAP_BITS-1:0] s2_lap_reg;
    temp_t                      s2_center_reg;
    temp_t                      s2_temp_reg;
    logic [ROW_BITS-1:0]        s2_row_reg;
    logic [AW-1:0]              s2_col_reg;
    logic                       s2_border_reg;
    logic                       s2_emit_reg;
    logic                       s2_last_row_reg;

    // multiply stage
    logic                        s3_valid_reg;
    logic signed [PROD_BITS-1:0] s3_prod_reg;
    temp_t                       s3_center_reg;
    temp_t                       s3_temp_reg;
    logic [ROW_BITS-1:0]         s3_row_reg;
    logic [AW-1:0]               s3_col_reg;
    logic                        s3_border_reg;
    logic                        s3_emit_reg;
    logic                        s3_last_row_reg;
    logic signed [ACC_BITS-1:0]  acc;
    temp_t                       stencil_val;

    // output register and pending second result
    logic                    out_valid_reg;
    temp_t                   out_temp_reg;
    logic [ROW_BITS-1:0]     out_row_reg;
    logic [OUT_COL_BITS-1:0] out_col_reg;
    logic                    out_last_reg;
    logic                    pend_reg;
    temp_t                   pend_temp_reg;
    logic [ROW_BITS-1:0]     pend_row_reg;
    logic [OUT_COL_BITS-1:0] pend_col_reg;
    logic                    out_fire;

    // flow control
    logic s1_adv;
    logic s2_adv;
    logic s3_adv;
    logic s2_ready;
    logic s3_ready;
    logic out_take;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    always_comb
    begin
        case (cfg_reg_t'(cfg.index))
            REG_GRID_WIDTH:  cfg_hit = 1'b1;
            REG_GRID_HEIGHT: cfg_hit = 1'b1;
            REG_DIFF_COEFF:  cfg_hit = 1'b1;
            default:         cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            coeff_reg       <= COEFF_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_GRID_WIDTH:  grid_width_reg  <= cfg.data[GW_BITS-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg.data[GH_BITS-1:0];
                REG_DIFF_COEFF:  coeff_reg       <= cfg.data[COEFF_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // clamp width to 3..MAX_WIDTH and height to at least 3
    always_comb
    begin
        gw_ext = WCMP'(grid_width_reg);
        if (gw_ext < WCMP'(MIN_DIM))
            eff_width = WCMP'(MIN_DIM);
        else if (gw_ext > WCMP'(MAX_WIDTH))
            eff_width = WCMP'(MAX_WIDTH);
        else
            eff_width = gw_ext;
        col_last = AW'(eff_width - WCMP'(1));

        if (grid_height_reg < GH_BITS'(MIN_DIM))
            row_last = ROW_BITS'(MIN_DIM - 1);
        else
            row_last = grid_height_reg - ROW_BITS'(1);
    end

    // ---------------- flow control ----------------
    assign out_fire = out_valid_reg && dout.ready;
    assign out_take = !out_valid_reg || (dout.ready && !pend_reg);
    assign s3_adv   = s3_valid_reg && out_take;
    assign s3_ready = !s3_valid_reg || s3_adv;
    assign s2_adv   = s2_valid_reg && s3_ready;
    assign s2_ready = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign din.ready = !s1_valid_reg || s1_adv;
    assign in_fire  = din.valid && din.ready;

    // ---------------- position counters ----------------
    assign col_at_last = (col_count_reg == col_last);
    assign row_at_last = (row_count_reg >= row_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (cfg_wr && cfg_hit)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (in_fire)
        begin
            if (col_at_last)
            begin
                col_count_reg <= '0;
                row_count_reg <= row_at_last ? '0 : row_count_reg + ROW_BITS'(1);
            end
            else
            begin
                col_count_reg <= col_count_reg + AW'(1);
            end
        end
    end

    // ---------------- read stage ----------------
    hds_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk          (clk),
        .rd_en        (in_fire),
        .rd_col       (col_count_reg),
        .rd_col_right (col_at_last ? col_count_reg : col_count_reg + AW'(1)),
        .taps         (taps),
        .wr_en        (s1_adv),
        .wr_col       (s1_col_reg),
        .wr_temp      (s1_temp_reg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_temp_reg     <= din.temperature_in;
            s1_row_reg      <= row_count_reg;
            s1_col_reg      <= col_count_reg;
            s1_last_row_reg <= row_at_last;
            s1_col_last_reg <= col_at_last;
            s1_emit_reg     <= (row_count_reg != '0);
        end
        // center of this column is the left neighbor of the next one
        if (s1_adv)
            left_reg <= taps.center;
    end

    assign nbr_sum = SUM_BITS'(taps.up) + SUM_BITS'(s1_temp_reg) + SUM_BITS'(left_reg)
                   + SUM_BITS'(taps.right);
    assign lap = $signed({1'b0, nbr_sum}) - $signed({1'b0, taps.center, 2'b00});

    // ---------------- laplacian stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_adv)
            s2_valid_reg <= 1'b1;
        else if (s2_adv)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_lap_reg      <= lap;
            s2_center_reg   <= taps.center;
            s2_temp_reg     <= s1_temp_reg;
            s2_row_reg      <= s1_row_reg;
            s2_col_reg      <= s1_col_reg;
            s2_border_reg   <= (s1_row_reg == ROW_BITS'(1)) || (s1_col_reg == '0)
                             || s1_col_last_reg;
            s2_emit_reg     <= s1_emit_reg;
            s2_last_row_reg <= s1_last_row_reg;
        end
    end

    // ---------------- multiply stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s2_adv)
            s3_valid_reg <= 1'b1;
        else if (s3_adv)
            s3_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s3_prod_reg     <= PROD_BITS'($signed({1'b0, coeff_reg}) * s2_lap_reg);
            s3_center_reg   <= s2_center_reg;
            s3_temp_reg     <= s2_temp_reg;
            s3_row_reg      <= s2_row_reg;
            s3_col_reg      <= s2_col_reg;
            s3_border_reg   <= s2_border_reg;
            s3_emit_reg     <= s2_emit_reg;
            s3_last_row_reg <= s2_last_row_reg;
        end
    end

    // round half up, then clamp to the temperature range
    always_comb
    begin
        acc = $signed({{(ACC_BITS - TEMP_BITS - FRAC_BITS){1'b0}}, s3_center_reg,
                       {FRAC_BITS{1'b0}}})
            + ACC_BITS'(s3_prod_reg)
            + $signed(ACC_BITS'(1) <<< (FRAC_BITS - 1));
        if (acc[ACC_BITS-1])
            stencil_val = '0;
        else if (|acc[ACC_BITS-2:FRAC_BITS+TEMP_BITS])
            stencil_val = '1;
        else
            stencil_val = acc[FRAC_BITS+TEMP_BITS-1:FRAC_BITS];
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (out_fire)
            begin
                if (pend_reg)
                    pend_reg <= 1'b0;
                else
                    out_valid_reg <= 1'b0;
            end
            if (s3_adv && s3_emit_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= s3_last_row_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv && s3_emit_reg)
        begin
            out_temp_reg  <= s3_border_reg ? s3_center_reg : stencil_val;
            out_row_reg   <= s3_row_reg - ROW_BITS'(1);
            out_col_reg   <= OUT_COL_BITS'(s3_col_reg);
            out_last_reg  <= !s3_last_row_reg;
            pend_temp_reg <= s3_temp_reg;
            pend_row_reg  <= s3_row_reg;
            pend_col_reg  <= OUT_COL_BITS'(s3_col_reg);
        end
        else if (out_fire && pend_reg)
        begin
            // last-row cell passes through as its own item
            out_temp_reg <= pend_temp_reg;
            out_row_reg  <= pend_row_reg;
            out_col_reg  <= pend_col_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign dout.valid           = out_valid_reg;
    assign dout.temperature_out = out_temp_reg;
    assign dout.out_row         = out_row_reg;
    assign dout.out_col         = out_col_reg;
    assign dout.last_of_run     = out_last_reg;

    // ---------------- checks ----------------
    `HDS_ASSERT_IMP(a_pend_behind_first, clk, rst_n, pend_reg, out_valid_reg && !out_last_reg)
    `HDS_ASSERT_IMP(a_col_in_range, clk, rst_n, 1'b1, col_count_reg <= col_last)
    `HDS_ASSERT_NEXT(a_col_wrap, clk, rst_n, in_fire && col_at_last && !cfg_wr, col_count_reg == '0)
    `HDS_ASSERT_IMP(a_stall_only_full, clk, rst_n, !din.ready, s1_valid_reg && !s2_ready)

endmodule
